// File: hdl/bdep_pkg.sv
`default_nettype none

package bdep_pkg;

  localparam int NUM_BUTTONS = 5;
  localparam int CODE_W      = $clog2(NUM_BUTTONS + 1);
  localparam int TIME_W      = 32;
  localparam int DEB_W       = 20;

  localparam logic [DEB_W-1:0] DEB_RESET = DEB_W'(50000);

  typedef logic [NUM_BUTTONS-1:0] btn_vec_t;
  typedef logic [TIME_W-1:0]      time_t;
  typedef logic [DEB_W-1:0]       deb_t;
  typedef logic [CODE_W-1:0]      code_t;

  typedef struct packed {
    btn_vec_t raw_buttons;
    time_t    now_us;
  } poll_t;

  typedef struct packed {
    code_t    event_code;
    btn_vec_t press_edges;
    btn_vec_t pressed_levels;
  } result_t;

  // lowest-numbered set bit wins; 0 when none
  function automatic code_t first_press(input btn_vec_t edges);
    code_t code;
    code = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (edges[i]) begin
        code = CODE_W'(i + 1);
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// File: hdl/bdep_ifs.sv
`default_nettype none

interface bdep_poll_if import bdep_pkg::*; ();
  logic     valid;
  logic     ready;
  btn_vec_t raw_buttons;
  time_t    now_us;

  modport source (output valid, output raw_buttons, output now_us, input ready);
  modport sink   (input valid, input raw_buttons, input now_us, output ready);
endinterface

interface bdep_result_if import bdep_pkg::*; ();
  logic     valid;
  logic     ready;
  code_t    event_code;
  btn_vec_t press_edges;
  btn_vec_t pressed_levels;

  modport source (output valid, output event_code, output press_edges,
                  output pressed_levels, input ready);
  modport sink   (input valid, input event_code, input press_edges,
                  input pressed_levels, output ready);
endinterface

interface bdep_cfg_if import bdep_pkg::*; ();
  logic valid;
  logic ready;
  deb_t debounce_time;

  modport source (output valid, output debounce_time, input ready);
  modport sink   (input valid, input debounce_time, output ready);
endinterface

`default_nettype wire

// File: hdl/bdep_in_stage.sv
`default_nettype none

module bdep_in_stage import bdep_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bdep_poll_if.sink   in_ch,
  input  wire logic   take,
  output logic        vld,
  output poll_t       item
);

  logic  vld_r;
  poll_t item_r;

  assign in_ch.ready = !vld_r || take;
  assign vld         = vld_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      vld_r <= 1'b1;
    end else if (take) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.raw_buttons <= in_ch.raw_buttons;
      item_r.now_us      <= in_ch.now_us;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bdep_core.sv
`default_nettype none

module bdep_core import bdep_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bdep_cfg_if.sink    cfg_ch,
  input  wire logic   fire,
  input  wire poll_t  item,
  output result_t     res
);

  deb_t     debounce_r;
  btn_vec_t last_raw_r;
  btn_vec_t stable_raw_r;
  btn_vec_t prev_pressed_r;
  time_t    change_time_r [NUM_BUTTONS];

  btn_vec_t stable_raw_nxt;
  btn_vec_t pressed;
  btn_vec_t edges;
  time_t    change_time_nxt [NUM_BUTTONS];
  time_t    elapsed [NUM_BUTTONS];

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      elapsed[i] = item.now_us - change_time_r[i];
      if (item.raw_buttons[i] != last_raw_r[i]) begin
        // changed this poll: change time restarts, level holds
        change_time_nxt[i] = item.now_us;
        stable_raw_nxt[i]  = stable_raw_r[i];
      end else begin
        change_time_nxt[i] = change_time_r[i];
        stable_raw_nxt[i]  = (elapsed[i] > TIME_W'(debounce_r)) ?
                             item.raw_buttons[i] : stable_raw_r[i];
      end
    end
    pressed = ~stable_raw_nxt;
    edges   = pressed & ~prev_pressed_r;
    res.event_code     = first_press(edges);
    res.press_edges    = edges;
    res.pressed_levels = pressed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r     <= DEB_RESET;
      last_raw_r     <= '1;
      stable_raw_r   <= '1;
      prev_pressed_r <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        change_time_r[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        debounce_r <= cfg_ch.debounce_time;
      end
      if (fire) begin
        last_raw_r     <= item.raw_buttons;
        stable_raw_r   <= stable_raw_nxt;
        prev_pressed_r <= pressed;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          change_time_r[i] <= change_time_nxt[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/bdep_out_stage.sv
`default_nettype none

module bdep_out_stage import bdep_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    s1_vld,
  input  wire result_t res,
  output logic         fire,
  bdep_result_if.source out_ch
);

  logic    vld_r;
  result_t res_r;
  logic    load;

  assign load = !vld_r || out_ch.ready;
  assign fire = s1_vld && load;

  assign out_ch.valid          = vld_r;
  assign out_ch.event_code     = res_r.event_code;
  assign out_ch.press_edges    = res_r.press_edges;
  assign out_ch.pressed_levels = res_r.pressed_levels;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// File: hdl/button_debounce_edge_priority.sv
`default_nettype none
// Path: a poll item accepted into the input register has its result held in the
//   result register once the output stage can load it.
// Throughput: one item per cycle unless out_ch stalls; per-button subtract/compare in parallel.
// Reset (rst_n, synchronous, active low): pipeline emptied, debounce time 50000,
//   last/stable raw all ones, change times and previous pressed mask zero.

module button_debounce_edge_priority import bdep_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  bdep_poll_if.sink     in_ch,
  bdep_result_if.source out_ch,
  bdep_cfg_if.sink      cfg_ch
);

  logic    s1_vld;
  poll_t   s1_item;
  logic    fire;
  result_t res;

  bdep_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (fire),
    .vld   (s1_vld),
    .item  (s1_item)
  );

  bdep_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .fire   (fire),
    .item   (s1_item),
    .res    (res)
  );

  bdep_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .s1_vld (s1_vld),
    .res    (res),
    .fire   (fire),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
